FILE: rtl/twc_pkg.sv
// Package for the thresholded watermark correlator: sizes, register indexes,
// item codes and the structures passed between the datapath modules.
// No dependencies.
`default_nettype none

package twc_pkg;

   // Watermark table and subband limits
   localparam int MAX_WM_LEN        = 32768;
   localparam int WM_ADDR_W         = $clog2(MAX_WM_LEN);
   localparam int MAX_SUBBAND_COEFS = 1048576;

   // Field widths
   localparam int COEF_W  = 24;
   localparam int WMV_W   = 16;
   localparam int PROD_W  = COEF_W + WMV_W;
   localparam int THR_W   = 23;
   localparam int LEN_W   = 16;
   localparam int COUNT_W = 21;
   localparam int CORR_W  = 64;
   localparam int MAG_W   = 47;

   // Count saturates at the smaller of the subband limit and the field maximum
   localparam int COUNT_FIELD_MAX = (1 << COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      COUNT_W'((MAX_SUBBAND_COEFS > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : MAX_SUBBAND_COEFS);

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 23;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_WM_LENGTH = CSR_IDX_W'(1);

   // Item kinds
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_COEF = 1'b1;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // One coefficient word entering the accumulate stage
   typedef struct packed {
      logic                     valid;
      logic                     sel;
      logic                     last;
      logic [COEF_W-1:0]        coef;
      logic signed [PROD_W-1:0] prod;
   } acc_in_type;

   // One result word
   typedef struct packed {
      logic [COUNT_W-1:0]       count;
      logic signed [CORR_W-1:0] correlation;
      logic [MAG_W-1:0]         magnitude_sum;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: rtl/thresholded_watermark_correlator.sv
// Thresholded watermark correlator, top level; depends on twc_pkg, twc_accum, twc_resp_fifo.
// Throughput: one word per cycle, loads and coefficients alike; the input stalls only
// while four result words are queued or on their way to the result queue.
// A result word passes stage one, stage two, the accumulator and the result queue before it is offered.
// Reset (synchronous): threshold to zero, length to one, clears position, accumulators and
// the result queue; the watermark table keeps its contents and has no clearing pass.
`default_nettype none

module thresholded_watermark_correlator
   import twc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Input words
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_mode,
   input  wire logic [WM_ADDR_W-1:0]     req_wm_index,
   input  wire logic signed [WMV_W-1:0]  req_wm_value,
   input  wire logic signed [COEF_W-1:0] req_coef,
   input  wire logic                     req_last,
   // Result words
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [COUNT_W-1:0]            rsp_count,
   output logic signed [CORR_W-1:0]      rsp_correlation,
   output logic [MAG_W-1:0]              rsp_magnitude_sum,
   // Register writes
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   logic [THR_W-1:0]         threshold_ff;
   logic [LEN_W-1:0]         wm_length_ff;
   logic [WM_ADDR_W-1:0]     position_ff, position_in;
   logic [LEN_W-1:0]         eff_len;
   logic [LEN_W-1:0]         pos_next;

   logic                     accept;
   logic                     coef_take;
   logic                     select;

   logic signed [WMV_W-1:0]  wm_mem [MAX_WM_LEN];
   logic signed [WMV_W-1:0]  wm_rd_ff;

   logic                     s1_valid_ff;
   logic                     s1_sel_ff;
   logic                     s1_last_ff;
   logic signed [COEF_W-1:0] s1_coef_ff;
   logic signed [PROD_W-1:0] prod;
   acc_in_type               s2_ff, s2_in;

   logic                     push;
   rsp_word_type             push_word;
   rsp_word_type             head_word;
   logic                     pop;
   logic [RSP_CNT_W-1:0]     fill;
   logic [RSP_CNT_W:0]       pending;

   // Configuration registers; writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         wm_length_ff <= LEN_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_THRESHOLD: threshold_ff <= csr_wdata[THR_W-1:0];
            REG_WM_LENGTH: wm_length_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Results in flight plus queued ones must never exceed the queue depth
   assign pending   = (RSP_CNT_W+1)'(fill)
                    + (RSP_CNT_W+1)'(s1_valid_ff & s1_last_ff)
                    + (RSP_CNT_W+1)'(s2_ff.valid & s2_ff.last);
   assign req_stall = (pending >= (RSP_CNT_W+1)'(RSP_DEPTH));

   assign accept    = req_valid & ~req_stall;
   assign coef_take = accept & (req_mode == MODE_COEF);

   // Signed compare of the coefficient against the unsigned threshold
   assign select = $signed({req_coef[COEF_W-1], req_coef})
                 > $signed({2'b00, threshold_ff});

   // Position wraps at the effective length (clamped to one and the table size) and restarts on a last coefficient
   always_comb begin
      if (wm_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (wm_length_ff > LEN_W'(MAX_WM_LEN)) begin
         eff_len = LEN_W'(MAX_WM_LEN);
      end else begin
         eff_len = wm_length_ff;
      end
      pos_next    = LEN_W'(position_ff) + LEN_W'(1);
      position_in = position_ff;
      if (coef_take) begin
         if (req_last || (pos_next >= eff_len)) begin
            position_in = '0;
         end else begin
            position_in = pos_next[WM_ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else begin
         position_ff <= position_in;
      end
   end

   // Watermark table: loads write, coefficients read at the current position.
   // A load and a later read of the same entry are never accepted in the same
   // cycle, so the read always sees the written value.
   always_ff @(posedge clock) begin
      if (accept && (req_mode == MODE_LOAD)) begin
         wm_mem[req_wm_index] <= req_wm_value;
      end
      if (coef_take) begin
         wm_rd_ff <= wm_mem[position_ff];
      end
   end

   // Stage one: coefficient waits beside the table read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= coef_take;
      end
   end

   always_ff @(posedge clock) begin
      if (coef_take) begin
         s1_sel_ff  <= select;
         s1_last_ff <= req_last;
         s1_coef_ff <= req_coef;
      end
   end

   // Stage two: registered product
   assign prod = s1_coef_ff * wm_rd_ff;

   always_comb begin
      s2_in.valid = s1_valid_ff;
      s2_in.sel   = s1_sel_ff;
      s2_in.last  = s1_last_ff;
      s2_in.coef  = s1_coef_ff;
      s2_in.prod  = prod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else begin
         s2_ff <= s2_in;
      end
   end

   twc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .acc_in    (s2_ff),
      .push      (push),
      .push_word (push_word)
   );

   assign pop = rsp_valid & ~rsp_stall;

   twc_resp_fifo u_resp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .fill      (fill)
   );

   assign rsp_valid         = (fill != '0);
   assign rsp_count         = head_word.count;
   assign rsp_correlation   = head_word.correlation;
   assign rsp_magnitude_sum = head_word.magnitude_sum;

   // The queue never takes a word while full unless one leaves in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (fill == RSP_CNT_W'(RSP_DEPTH))))
      else $error("result queue overflow");

   // Admission control keeps in-flight results within the queue depth
   assert property (@(posedge clock) disable iff (reset)
      pending <= (RSP_CNT_W+1)'(RSP_DEPTH))
      else $error("too many results in flight");

   // A subband's last coefficient restarts the position
   assert property (@(posedge clock) disable iff (reset)
      (coef_take && req_last) |=> (position_ff == '0))
      else $error("position not cleared after last coefficient");

   // Every last coefficient taken yields a result push once it has passed stage one and stage two
   assert property (@(posedge clock) disable iff (reset)
      (coef_take && req_last) |-> ##2 push)
      else $error("result missing for last coefficient");

endmodule

`default_nettype wire

FILE: rtl/twc_accum.sv
// Accumulate stage: saturating correlation, magnitude and count accumulators,
// emitting a result word and clearing on the last coefficient of a subband.
// Depends on twc_pkg.
`default_nettype none

module twc_accum
   import twc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire acc_in_type   acc_in,
   output logic              push,
   output rsp_word_type      push_word
);

   logic [COUNT_W-1:0]       count_ff, count_in, count_upd;
   logic signed [CORR_W-1:0] corr_ff, corr_in, corr_upd;
   logic [MAG_W-1:0]         mag_ff, mag_in, mag_upd;
   logic signed [CORR_W:0]   corr_sum;
   logic [MAG_W:0]           mag_sum;

   // Saturating updates for a selected coefficient
   always_comb begin
      corr_sum = {corr_ff[CORR_W-1], corr_ff} + (CORR_W+1)'(acc_in.prod);
      mag_sum  = {1'b0, mag_ff} + (MAG_W+1)'(acc_in.coef[COEF_W-2:0]);

      corr_upd  = corr_ff;
      mag_upd   = mag_ff;
      count_upd = count_ff;
      if (acc_in.sel) begin
         // Top two bits differing means the sum left the 64-bit range
         if (corr_sum[CORR_W:CORR_W-1] == 2'b01) begin
            corr_upd = {1'b0, {(CORR_W-1){1'b1}}};
         end else if (corr_sum[CORR_W:CORR_W-1] == 2'b10) begin
            corr_upd = {1'b1, {(CORR_W-1){1'b0}}};
         end else begin
            corr_upd = corr_sum[CORR_W-1:0];
         end
         mag_upd = mag_sum[MAG_W] ? {MAG_W{1'b1}} : mag_sum[MAG_W-1:0];
         if (count_ff < COUNT_CAP) begin
            count_upd = count_ff + COUNT_W'(1);
         end
      end
   end

   // Result on the last word, then clear for the next subband
   always_comb begin
      push                    = acc_in.valid & acc_in.last;
      push_word.count         = count_upd;
      push_word.correlation   = corr_upd;
      push_word.magnitude_sum = mag_upd;
      count_in = count_ff;
      corr_in  = corr_ff;
      mag_in   = mag_ff;
      if (acc_in.valid) begin
         if (acc_in.last) begin
            count_in = '0;
            corr_in  = '0;
            mag_in   = '0;
         end else begin
            count_in = count_upd;
            corr_in  = corr_upd;
            mag_in   = mag_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         corr_ff  <= '0;
         mag_ff   <= '0;
      end else begin
         count_ff <= count_in;
         corr_ff  <= corr_in;
         mag_ff   <= mag_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/twc_resp_fifo.sv
// Small result queue that decouples the accumulate stage from the result
// channel. Depends on twc_pkg.
`default_nettype none

module twc_resp_fifo
   import twc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire rsp_word_type  push_word,
   input  wire logic          pop,
   output rsp_word_type       head_word,
   output logic [RSP_CNT_W-1:0] fill
);

   rsp_word_type              entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]      fill_ff, fill_in;

   // Pointer and fill updates
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage holds payload only
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head_word = entry_ff[rd_ptr_ff];
   assign fill      = fill_ff;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the thresholded watermark correlator: directed and
// random coefficient and watermark-load words, checked by a scoreboard predictor.
// Depends on twc_pkg and the thresholded_watermark_correlator top level.
`default_nettype none

module tb_top
   import twc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     WORD_TARGET   = 1650;
   localparam int     CYCLE_LIMIT   = 200000;
   localparam int     SETTLE_CYCLES = 12;
   localparam int     HOLD_CYCLES   = 400;
   localparam longint CORR_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint CORR_MIN      = 64'sh8000_0000_0000_0000;
   localparam longint MAG_LIMIT     = (64'sd1 <<< MAG_W) - 1;
   localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
   localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;
   localparam logic signed [WMV_W-1:0]  WMV_MAX  = 16'sh7FFF;
   localparam logic signed [WMV_W-1:0]  WMV_MIN  = 16'sh8000;

   // One input word as it crosses the request channel
   typedef struct packed {
      logic                     mode;
      logic [WM_ADDR_W-1:0]     wm_index;
      logic signed [WMV_W-1:0]  wm_value;
      logic signed [COEF_W-1:0] coef;
      logic                     last;
   } input_word_type;

   // Predicts the correlator's results and checks each result word in order.
   class watermark_scoreboard;
      int unsigned             threshold;
      int unsigned             wm_length;
      logic signed [WMV_W-1:0] wm_tab [MAX_WM_LEN];
      bit                      written [MAX_WM_LEN];
      int                      position;
      int                      count_acc;
      longint                  corr_acc;
      longint                  mag_acc;
      rsp_word_type            expected_q [$];
      int                      words, loads, coefs, results, mismatches;

      function new();
         threshold = 0;
         wm_length = 1;
         position = 0;
         count_acc = 0;
         corr_acc = 0;
         mag_acc = 0;
         words = 0;
         loads = 0;
         coefs = 0;
         results = 0;
         mismatches = 0;
      endfunction

      function void note_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_THRESHOLD: threshold = int'(data[THR_W-1:0]);
            REG_WM_LENGTH: wm_length = int'(data[LEN_W-1:0]);
            default: ;
         endcase
      endfunction

      // Applies one accepted input word and queues any result it causes.
      function void note_word(input_word_type w);
         int           len;
         longint       prod;
         longint       sum;
         rsp_word_type exp_word;
         words++;
         if (w.mode == MODE_LOAD) begin
            loads++;
            wm_tab[w.wm_index] = w.wm_value;
            written[w.wm_index] = 1'b1;
            return;
         end
         coefs++;
         // Only coefficients strictly above the threshold take part.
         if (longint'($signed(w.coef)) > longint'(threshold)) begin
            prod = longint'($signed(w.coef)) * longint'(wm_tab[position]);
            sum = corr_acc + prod;
            if (prod > 0 && corr_acc > 0 && sum < 0)
               sum = CORR_MAX;
            else if (prod < 0 && corr_acc < 0 && sum >= 0)
               sum = CORR_MIN;
            corr_acc = sum;
            mag_acc = mag_acc + longint'($signed(w.coef));
            if (mag_acc > MAG_LIMIT)
               mag_acc = MAG_LIMIT;
            if (count_acc < int'(COUNT_CAP))
               count_acc++;
         end
         // The position steps on every coefficient and wraps at the effective length.
         len = int'(wm_length);
         if (len == 0)
            len = 1;
         if (len > MAX_WM_LEN)
            len = MAX_WM_LEN;
         position = (position + 1 >= len) ? 0 : position + 1;
         if (w.last) begin
            exp_word.count = COUNT_W'(count_acc);
            exp_word.correlation = corr_acc;
            exp_word.magnitude_sum = MAG_W'(mag_acc);
            expected_q.push_back(exp_word);
            count_acc = 0;
            corr_acc = 0;
            mag_acc = 0;
            position = 0;
         end
      endfunction

      // Compares one accepted result word with the oldest prediction.
      function void check_result(rsp_word_type got);
         rsp_word_type exp_word;
         results++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result with nothing expected: count=%0d corr=%0d mag=%0d",
                        got.count, got.correlation, got.magnitude_sum);
            return;
         end
         exp_word = expected_q.pop_front();
         if (got.count !== exp_word.count || got.correlation !== exp_word.correlation ||
             got.magnitude_sum !== exp_word.magnitude_sum) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result %0d: expected count=%0d corr=%0d mag=%0d",
                        results, exp_word.count, exp_word.correlation,
                        exp_word.magnitude_sum);
               $display("       got count=%0d corr=%0d mag=%0d",
                        got.count, got.correlation, got.magnitude_sum);
            end
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_mode;
   logic [WM_ADDR_W-1:0]     req_wm_index;
   logic signed [WMV_W-1:0]  req_wm_value;
   logic signed [COEF_W-1:0] req_coef;
   logic                     req_last;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [COUNT_W-1:0]       rsp_count;
   logic signed [CORR_W-1:0] rsp_correlation;
   logic [MAG_W-1:0]         rsp_magnitude_sum;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   watermark_scoreboard sb;
   bit calm;
   bit hold_request;
   int cycle_count;
   int settings;

   thresholded_watermark_correlator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_wm_index      (req_wm_index),
      .req_wm_value      (req_wm_value),
      .req_coef          (req_coef),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_count         (rsp_count),
      .rsp_correlation   (rsp_correlation),
      .rsp_magnitude_sum (rsp_magnitude_sum),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit, counted in clock cycles.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: takes words, stalls at random after each one unless calm, and
   // holds off for a long stretch when asked.
   initial begin
      int wait_left;
      int hold_left;
      wait_left = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            sb.check_result('{count: rsp_count, correlation: rsp_correlation,
                              magnitude_sum: rsp_magnitude_sum});
            wait_left = calm ? 0 : $urandom_range(0, 3);
         end
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one word after a random gap and waits until it is taken.
   task automatic send_word(input_word_type w);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= w.mode;
      req_wm_index <= w.wm_index;
      req_wm_value <= w.wm_value;
      req_coef <= w.coef;
      req_last <= w.last;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
   endtask

   task automatic send_load(int idx, logic signed [WMV_W-1:0] value, bit is_last);
      input_word_type w;
      w.mode = MODE_LOAD;
      w.wm_index = WM_ADDR_W'(idx);
      w.wm_value = value;
      w.coef = COEF_W'($urandom());
      w.last = is_last;
      send_word(w);
   endtask

   // Sends a coefficient, first loading the table entry it will read if that
   // entry has never been written.
   task automatic send_coef(logic signed [COEF_W-1:0] c, bit is_last);
      input_word_type w;
      if (!sb.written[sb.position])
         send_load(sb.position, WMV_W'($urandom()), 1'($urandom_range(0, 1)));
      w.mode = MODE_COEF;
      w.wm_index = WM_ADDR_W'($urandom());
      w.wm_value = WMV_W'($urandom());
      w.coef = c;
      w.last = is_last;
      send_word(w);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.note_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_registers(int unsigned thr, int unsigned len);
      write_reg(REG_THRESHOLD, CSR_DATA_W'(thr));
      write_reg(REG_WM_LENGTH, CSR_DATA_W'(len));
      settings++;
   endtask

   // Waits until every predicted result has come, then lets the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2, 3: return COEF_W'(int'(sb.threshold) + $urandom_range(0, 4) - 2);
         4, 5, 6: return COEF_W'($urandom());
         default: return COEF_W'($urandom_range(0, (1 << (COEF_W - 1)) - 1));
      endcase
   endfunction

   function automatic int unsigned pick_threshold();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return (1 << THR_W) - 1;
         2, 3: return $urandom_range(0, 255);
         4: return $urandom_range(0, (1 << THR_W) - 1);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic int unsigned pick_length();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return MAX_WM_LEN;
         3: return (1 << LEN_W) - 1;
         4: return $urandom_range(MAX_WM_LEN + 1, (1 << LEN_W) - 1);
         5: return $urandom_range(17, 300);
         default: return $urandom_range(1, 16);
      endcase
   endfunction

   initial begin
      int  n_sub;
      int  n_coef;
      bit  open_end;
      sb = new();
      calm = 1'b0;
      hold_request = 1'b0;
      settings = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_LOAD;
      req_wm_index <= '0;
      req_wm_value <= '0;
      req_coef <= '0;
      req_last <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= REG_THRESHOLD;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: table extremes, a load carrying the last flag, coefficient
      // extremes, a one-word subband and a threshold equal to the coefficient.
      set_registers(0, 4);
      send_load(0, WMV_MAX, 1'b0);
      send_load(1, WMV_MIN, 1'b0);
      send_load(2, 16'sd0, 1'b1);
      send_load(3, -16'sd1, 1'b0);
      send_load(MAX_WM_LEN - 1, 16'sh5555, 1'b0);
      send_coef(COEF_MAX, 1'b0);
      send_coef(COEF_MAX, 1'b0);
      send_coef(COEF_MIN, 1'b0);
      send_coef(24'sd0, 1'b0);
      send_coef(24'sd1, 1'b0);
      send_coef(COEF_MAX, 1'b1);
      send_coef(24'sd1, 1'b1);
      drain();

      // Highest threshold selects nothing; a length of zero behaves as one.
      set_registers((1 << THR_W) - 1, 0);
      send_coef(COEF_MAX, 1'b0);
      send_coef(-24'sd1, 1'b1);
      drain();

      // An over-long length is clipped; the subband is left open so that the
      // next length is applied part-way through it.
      set_registers(100, (1 << LEN_W) - 1);
      send_coef(24'sd100, 1'b0);
      send_coef(24'sd101, 1'b0);
      send_coef(COEF_MAX, 1'b0);
      send_coef(24'sd99, 1'b0);
      send_coef(24'sd5000, 1'b0);
      send_coef(COEF_MAX, 1'b0);
      drain();
      write_reg(REG_WM_LENGTH, CSR_DATA_W'(3));
      settings++;
      send_coef(24'sd200, 1'b0);
      send_coef(24'sd300, 1'b1);
      drain();

      // Random phases, each under a fresh register setting.
      while (sb.words < WORD_TARGET) begin
         set_registers(pick_threshold(), pick_length());
         if (settings == 6) begin
            // Result side holds off while short subbands keep arriving back to back.
            hold_request = 1'b1;
            calm = 1'b1;
            repeat (40) begin
               if ($urandom_range(0, 1))
                  send_coef(pick_coef(), 1'b0);
               send_coef(pick_coef(), 1'b1);
            end
            calm = 1'b0;
         end else begin
            calm = (settings % 4 == 2);
            n_sub = $urandom_range(2, 6);
            for (int s = 0; s < n_sub; s++) begin
               n_coef = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150)
                                                    : $urandom_range(1, 24);
               open_end = (s == n_sub - 1) && ($urandom_range(0, 3) == 0);
               for (int k = 0; k < n_coef; k++) begin
                  if ($urandom_range(0, 7) == 0) begin
                     if ($urandom_range(0, 1))
                        send_load($urandom_range(0, MAX_WM_LEN - 1), WMV_W'($urandom()),
                                  1'($urandom_range(0, 1)));
                     else
                        send_load($urandom_range(0, 63), WMV_W'($urandom()),
                                  1'($urandom_range(0, 1)));
                  end
                  send_coef(pick_coef(), (k == n_coef - 1) && !open_end);
               end
            end
            calm = 1'b0;
         end
         drain();
      end

      $display("Covered %0d input words (%0d loads, %0d coefficients) over %0d register settings.",
               sb.words, sb.loads, sb.coefs, settings);
      $display("Checked %0d result words, %0d mismatching.", sb.results, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

FILE: thresholded_watermark_correlator.f
rtl/twc_pkg.sv
rtl/twc_accum.sv
rtl/twc_resp_fifo.sv
rtl/thresholded_watermark_correlator.sv
tb/tb_top.sv
